[src/pmat_pkg.sv]
// Shared types and constants for the protected mode address translator.
package pmat_pkg;

	// Command codes of an input item
	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_WRITE     = 3'd1;
	localparam logic [2:0] CMD_INSN_BEGIN = 3'd2;
	localparam logic [2:0] CMD_INSN_END  = 3'd3;
	localparam logic [2:0] CMD_EXCEPTION = 3'd4;

	// Target codes of a result item
	localparam logic [3:0] TGT_NONE     = 4'd0;
	localparam logic [3:0] TGT_MAIN_RAM = 4'd1;
	localparam logic [3:0] TGT_SYSTEM   = 4'd2;
	localparam logic [3:0] TGT_VIDEO    = 4'd3;
	localparam logic [3:0] TGT_SERIAL   = 4'd4;
	localparam logic [3:0] TGT_KEYBOARD = 4'd5;
	localparam logic [3:0] TGT_DISC     = 4'd6;
	localparam logic [3:0] TGT_FLOPPY   = 4'd7;
	localparam logic [3:0] TGT_TIMER    = 4'd8;
	localparam logic [3:0] TGT_NETWORK  = 4'd9;
	localparam logic [3:0] TGT_INTERNAL = 4'd10;

	// System-space address map
	localparam logic [15:0] ADDR_IO_BASE    = 16'hE000;
	localparam logic [15:0] ADDR_SYS_BASE   = 16'hE800;
	localparam logic [15:0] ADDR_TEXT1_END  = 16'hEBC0;
	localparam logic [15:0] ADDR_TEXT2_BASE = 16'hEC00;
	localparam logic [15:0] ADDR_TEXT2_END  = 16'hEFC0;
	localparam logic [15:0] ADDR_ROM_BASE   = 16'hF000;
	localparam logic [15:0] ADDR_BAUD       = 16'hE006;
	localparam logic [15:0] ADDR_DRIVE_SEL  = 16'hE014;
	localparam logic [15:0] ADDR_LEAVE      = 16'hE040;
	localparam logic [15:0] ADDR_PAGE_BASE  = 16'hE050;
	localparam logic [15:0] ADDR_MAP_ONE    = 16'hE060;
	localparam logic [15:0] ADDR_MAP_TWO    = 16'hE070;

	localparam int PT_DEPTH = 16;
	localparam int PT_AW    = 4;

	// Architectural control state
	typedef struct packed {
		logic       map_two;
		logic       prot;
		logic       leave_req;
		logic       leave_armed;
		logic [7:0] drive_sel;
		logic [7:0] baud;
	} state_t;

	// Decode of one item, carried to the result stage
	typedef struct packed {
		logic [3:0]  target;
		logic        xlate;       // main RAM, address goes through page table
		logic        pt_read;     // read of a page register
		logic [15:0] addr;
		logic [2:0]  dev_offset;
		logic        mem_write;   // before ROM filtering on translated writes
		logic [7:0]  read_data;
		logic        data_from_block;
		logic        screen_write;
		logic        door_clear;
		logic [1:0]  door_drive;
	} dec_t;

endpackage

[src/pmat_ram.sv]
// Generic RAM: one write port, two registered read ports.
module pmat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[src/pmat_decode.sv]
// Command and address decode with control state update for one item.
module pmat_decode import pmat_pkg::*; (
	input  logic [2:0]  cmd,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  state_t      cur,
	output state_t      nxt,
	output logic        pt_we,
	output dec_t        dec
);

	logic wr;
	logic access;

	assign wr     = (cmd == CMD_WRITE);
	assign access = (cmd == CMD_READ) || (cmd == CMD_WRITE);

	always_comb begin
		nxt   = cur;
		pt_we = 1'b0;
		dec   = '0;
		dec.addr = address;
		case (cmd)
			CMD_INSN_BEGIN: begin
				nxt.leave_armed = cur.prot & cur.leave_req;
			end
			CMD_INSN_END: begin
				if (cur.leave_armed) begin
					nxt.leave_req = 1'b0;
					nxt.prot      = 1'b0;
				end
				nxt.leave_armed = 1'b0;
			end
			CMD_EXCEPTION: begin
				nxt.prot = 1'b1;
			end
			default: begin
				if (access) begin
					if (!cur.prot || address < ADDR_IO_BASE) begin
						dec.target    = TGT_MAIN_RAM;
						dec.xlate     = 1'b1;
						dec.mem_write = wr;
					end else if (address >= ADDR_SYS_BASE) begin
						dec.target = TGT_SYSTEM;
						if (wr && address < ADDR_ROM_BASE) begin
							dec.mem_write    = 1'b1;
							dec.screen_write = (address < ADDR_TEXT1_END) ||
								(address >= ADDR_TEXT2_BASE && address < ADDR_TEXT2_END);
						end
					end else if (address inside {[16'hE000:16'hE003]}) begin
						dec.target     = TGT_VIDEO;
						dec.dev_offset = {1'b0, address[1:0]};
					end else if (address inside {[16'hE004:16'hE005]}) begin
						dec.target     = TGT_SERIAL;
						dec.dev_offset = {2'b00, address[0]};
					end else if (address == ADDR_BAUD) begin
						dec.target = TGT_INTERNAL;
						if (wr) begin
							nxt.baud = write_data;
						end else begin
							dec.read_data       = cur.baud;
							dec.data_from_block = 1'b1;
						end
					end else if (address inside {[16'hE00C:16'hE00F]}) begin
						dec.target     = TGT_KEYBOARD;
						dec.dev_offset = {1'b0, address[1:0]};
					end else if (address == ADDR_DRIVE_SEL) begin
						dec.target = TGT_DISC;
						if (wr && write_data != cur.drive_sel) begin
							dec.door_clear = 1'b1;
							dec.door_drive = cur.drive_sel[1:0];
							nxt.drive_sel  = write_data;
						end
					end else if (address inside {[16'hE018:16'hE01B]}) begin
						dec.target     = TGT_FLOPPY;
						dec.dev_offset = {1'b0, address[1:0]};
					end else if (address inside {[16'hE020:16'hE027]}) begin
						dec.target     = TGT_TIMER;
						dec.dev_offset = address[2:0];
					end else if (address inside {[16'hE030:16'hE036]}) begin
						dec.target     = TGT_NETWORK;
						dec.dev_offset = {1'b0, address[2:1]};
					end else if (address == ADDR_LEAVE) begin
						dec.target = TGT_INTERNAL;
						if (wr) begin
							nxt.leave_req = 1'b1;
						end else begin
							dec.data_from_block = 1'b1;
						end
					end else if (address inside {[16'hE050:16'hE05F]}) begin
						dec.target = TGT_INTERNAL;
						if (wr) begin
							pt_we = 1'b1;
						end else begin
							dec.pt_read         = 1'b1;
							dec.data_from_block = 1'b1;
						end
					end else if (address == ADDR_MAP_ONE || address == ADDR_MAP_TWO) begin
						dec.target = TGT_INTERNAL;
						if (wr) begin
							nxt.map_two = (address == ADDR_MAP_TWO);
						end else begin
							dec.data_from_block = 1'b1;
						end
					end else begin
						// undecoded I/O hole: reads answer zero, writes vanish
						dec.target          = TGT_NONE;
						dec.data_from_block = !wr;
					end
				end
			end
		endcase
	end

endmodule

[src/protected_mode_address_translator_unit.sv]
// Top level of the protected mode address translator: handshake, state, page table, result.
//
// One bus access or processor event enters per cycle while the output side is ready and gives
// exactly one result item, through stage 1 and the output register. At the accepting edge the
// command is decoded against the control state (protected flag, map select, leave-protect
// request and arm, drive select, baud register), that state is updated, and the page
// register file is read at two addresses: the translation entry {map select, address 15:13}
// and the page register addressed for an internal read at 0xE050-0xE05F. The read data is
// registered with the decode in stage 1; the next stage inverts the entry into physical bits
// 20..13, applies the ROM write filter for 0xC000-0xFFFF and loads the output register.
// A page register write lands at the accepting edge, so the next item already sees it.
// The page registers power up as zero through per-entry valid bits. Stage 1 keeps accepting
// while a result waits in the output register, so a stalled consumer costs one extra item
// of buffering before s_tready drops.
module protected_mode_address_translator_unit import pmat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// phys_address[20:0], dev_offset[23:21], mem_write[24], read_data[32:25],
	// data_from_block[33], screen_write[34], door_clear[35], door_drive[37:36],
	// drive[39:38], prot_mode[40], zero fill[47:41]
	output logic [47:0] m_tdata,
	output logic [3:0]  m_tuser    // target[3:0]
);

	logic [2:0]  cmd;
	logic [15:0] address;
	logic [7:0]  write_data;

	assign cmd        = s_tuser;
	assign address    = s_tdata[15:0];
	assign write_data = s_tdata[23:16];

	// control state
	state_t cur_q;
	state_t nxt;
	logic   pt_we;
	dec_t   dec;

	logic [PT_DEPTH-1:0] pt_valid_q;
	logic [PT_AW-1:0]    x_idx;
	logic [PT_AW-1:0]    p_idx;
	logic [7:0]          x_data;
	logic [7:0]          p_data;

	// handshake
	logic valid_s1;
	logic out_valid_q;
	logic accept;
	logic adv;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	pmat_decode u_decode (
		.cmd        (cmd),
		.address    (address),
		.write_data (write_data),
		.cur        (cur_q),
		.nxt        (nxt),
		.pt_we      (pt_we),
		.dec        (dec)
	);

	assign x_idx = {cur_q.map_two, address[15:13]};
	assign p_idx = address[3:0];

	pmat_ram #(
		.WIDTH (8),
		.DEPTH (PT_DEPTH)
	) u_page_table (
		.clk     (clk),
		.we      (accept && pt_we),
		.waddr   (p_idx),
		.wdata   (write_data),
		.re      (accept),
		.raddr_a (x_idx),
		.raddr_b (p_idx),
		.rdata_a (x_data),
		.rdata_b (p_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{
				map_two:     1'b0,
				prot:        1'b1,
				leave_req:   1'b0,
				leave_armed: 1'b0,
				drive_sel:   8'h00,
				baud:        8'h00
			};
			pt_valid_q <= '0;
		end else if (accept) begin
			cur_q <= nxt;
			if (pt_we) begin
				pt_valid_q[p_idx] <= 1'b1;
			end
		end
	end

	// stage 1: decode and post-item state, page table data arrives from the RAM
	dec_t       dec_s1;
	logic [1:0] drive_s1;
	logic       prot_s1;
	logic       x_valid_s1;
	logic       p_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1     <= dec;
			drive_s1   <= nxt.drive_sel[1:0];
			prot_s1    <= nxt.prot;
			x_valid_s1 <= pt_valid_q[x_idx];
			p_valid_s1 <= pt_valid_q[p_idx];
		end
	end

	// result: translation and ROM filter
	logic [7:0]  x_entry;
	logic [7:0]  p_entry;
	logic [7:0]  top;
	logic        rom_hit;
	logic [20:0] phys;
	logic        mw;
	logic [7:0]  rd;

	assign x_entry = x_valid_s1 ? x_data : 8'h00;
	assign p_entry = p_valid_s1 ? p_data : 8'h00;
	assign top     = ~x_entry;
	// physical 0xC000-0xFFFF: bits 20..16 clear, bits 15..14 set
	assign rom_hit = (top[7:3] == 5'd0) && (top[2:1] == 2'b11);

	always_comb begin
		if (dec_s1.xlate) begin
			phys = {top, dec_s1.addr[12:0]};
			mw   = dec_s1.mem_write && !rom_hit;
		end else begin
			phys = (dec_s1.target == TGT_SYSTEM) ? {5'd0, dec_s1.addr} : 21'd0;
			mw   = dec_s1.mem_write;
		end
		rd = dec_s1.pt_read ? p_entry : dec_s1.read_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [47:0] tdata_q;
	logic [3:0]  tuser_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			tuser_q <= dec_s1.target;
			tdata_q <= {7'd0, prot_s1, drive_s1, dec_s1.door_drive, dec_s1.door_clear,
				dec_s1.screen_write, dec_s1.data_from_block, rd, mw,
				dec_s1.dev_offset, phys};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

endmodule

[src/pmat_checker.sv]
// Port-level checker for the address translator, bound to the top level.
module pmat_checker import pmat_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [3:0]  m_tuser
);

	// a block-answered read never performs a memory write
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> !m_tdata[24])
		else $error("data_from_block together with mem_write");

	// screen changes only come from system RAM writes that are performed
	a_screen_sys: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[24] && (m_tuser == TGT_SYSTEM))
		else $error("screen_write outside a system RAM write");

	// door clear only on the disc target
	a_door_disc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> (m_tuser == TGT_DISC))
		else $error("door_clear on a non-disc target");

	// only memory targets carry a physical address
	a_phys_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != TGT_MAIN_RAM) && (m_tuser != TGT_SYSTEM)
		|-> (m_tdata[20:0] == 21'd0))
		else $error("phys_address on a device target");

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

endmodule

bind protected_mode_address_translator_unit pmat_checker u_pmat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
